@@ hw/rtl/cln_pkg.sv @@
package cln_pkg;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_BYTE  = 3'd1;
  localparam logic [2:0] CMD_CHAR  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_HOME  = 3'd4;
  localparam logic [2:0] CMD_GOTO  = 3'd5;

  localparam logic [7:0]  CLEAR_BYTE      = 8'h01;
  localparam logic [7:0]  SETADDR_BYTE    = 8'h80;
  localparam logic [12:0] CLEAR_WAIT_US   = 13'd3000;
  localparam logic [16:0] START_WAIT_US   = 17'd100000;
  localparam logic [4:0]  INIT_LAST_STEP  = 5'd19;

  typedef struct packed {
    logic        is_init;
    logic        rs;
    logic [7:0]  data;
    logic [12:0] wait_after;
  } entry_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [16:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } result_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h30;
      4'd1:    b = 8'h30;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h20;
      4'd4:    b = 8'h28;
      4'd5:    b = 8'h08;
      4'd6:    b = 8'h01;
      4'd7:    b = 8'h0C;
      4'd8:    b = 8'h06;
      4'd9:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [12:0] init_wait(input logic [3:0] idx);
    logic [12:0] w;
    case (idx)
      4'd0:    w = 13'd5000;
      4'd1:    w = 13'd100;
      4'd2:    w = 13'd100;
      4'd3:    w = 13'd100;
      4'd4:    w = 13'd40;
      4'd6:    w = 13'd3000;
      4'd9:    w = 13'd3000;
      default: w = 13'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/cln_front.sv @@
module cln_front (
  input  logic             start,
  input  logic             busy,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_byte_value,
  input  logic [7:0]       in_column,
  input  logic [1:0]       in_row,
  output logic             push,
  output cln_pkg::entry_t  entry
);
  import cln_pkg::*;

  logic known;

  always_comb begin
    known            = 1'b1;
    entry.is_init    = 1'b0;
    entry.rs         = 1'b0;
    entry.data       = in_byte_value;
    entry.wait_after = '0;
    case (in_command)
      CMD_INIT: begin
        entry.is_init = 1'b1;
      end
      CMD_BYTE: begin
      end
      CMD_CHAR: begin
        entry.rs = 1'b1;
      end
      CMD_CLEAR: begin
        entry.data       = CLEAR_BYTE;
        entry.wait_after = CLEAR_WAIT_US;
      end
      CMD_HOME: begin
        entry.data = SETADDR_BYTE;
      end
      CMD_GOTO: begin
        entry.data = SETADDR_BYTE + row_base(in_row) + in_column;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = start && !busy && known;

endmodule

@@ hw/rtl/cln_queue.sv @@
module cln_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cln_pkg::entry_t  push_entry,
  input  logic             pop,
  output cln_pkg::entry_t  head,
  output logic             empty,
  output logic             full
);
  import cln_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/cln_back.sv @@
module cln_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cln_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             strobe,
  output cln_pkg::result_t result
);
  import cln_pkg::*;

  logic       active_r, active_nxt;
  entry_t     entry_r, entry_nxt;
  logic [4:0] step_r, step_nxt;
  logic       strobe_r;
  result_t    result_r, result_nxt;
  logic       done_now;
  logic [7:0] cur_byte;

  assign done_now = active_r && (entry_r.is_init ? (step_r == INIT_LAST_STEP) : step_r[0]);
  assign pop      = !empty && (!active_r || done_now);

  always_comb begin
    cur_byte = entry_r.is_init ? init_byte(step_r[4:1]) : entry_r.data;
    result_nxt.rs          = entry_r.rs;
    result_nxt.nibble      = step_r[0] ? cur_byte[3:0] : cur_byte[7:4];
    result_nxt.wait_before = (entry_r.is_init && step_r == '0) ? START_WAIT_US : '0;
    if (!step_r[0]) begin
      result_nxt.wait_after = '0;
    end else if (entry_r.is_init) begin
      result_nxt.wait_after = init_wait(step_r[4:1]);
    end else begin
      result_nxt.wait_after = entry_r.wait_after;
    end
    result_nxt.last = done_now;
  end

  always_comb begin
    active_nxt = active_r;
    entry_nxt  = entry_r;
    step_nxt   = step_r;
    if (pop) begin
      active_nxt = 1'b1;
      entry_nxt  = head;
      step_nxt   = '0;
    end else if (done_now) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r  <= entry_nxt;
    step_r   <= step_nxt;
    result_r <= result_nxt;
  end

  assign strobe = strobe_r;
  assign result = result_r;

endmodule

@@ hw/rtl/char_lcd_nibble_writer.sv @@
// Channel  Handshake            Payload
// in       start / busy         in_command, in_byte_value, in_column, in_row
// out      out_strobe           out_register_select, out_nibble, out_wait_before_us,
//                               out_wait_after_us, out_last
// cfg      cfg_we               cfg_enable_pulse_us
// Each item leaves as nibbles, high nibble first: an init item gives 20 nibbles, every
// other item 2; an unused command code is never queued.
// An item is accepted whenever the queue of QUEUE_DEPTH items has room; busy means full.
// The head item is loaded into the entry and step registers; results are registered.
// Reset is synchronous and active low; the pulse width register resets to 30.
// The receiver cannot stall, so the sequencer never waits on the output side.
module char_lcd_nibble_writer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic [7:0]  in_column,
  input  logic [1:0]  in_row,
  output logic        out_strobe,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic [16:0] out_wait_before_us,
  output logic [12:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_enable_pulse_us
);
  import cln_pkg::*;

  logic       push;
  logic       pop;
  logic       empty;
  logic       full;
  entry_t     push_entry;
  entry_t     head;
  result_t    result;
  logic [7:0] enable_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r <= 8'd30;
    end else if (cfg_we) begin
      enable_pulse_r <= cfg_enable_pulse_us;
    end
  end

  assign busy = full;

  cln_front u_front (
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_byte_value (in_byte_value),
    .in_column     (in_column),
    .in_row        (in_row),
    .push          (push),
    .entry         (push_entry)
  );

  cln_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  cln_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .strobe (out_strobe),
    .result (result)
  );

  assign out_register_select = result.rs;
  assign out_nibble          = result.nibble;
  assign out_wait_before_us  = result.wait_before;
  assign out_wait_after_us   = result.wait_after;
  assign out_last            = result.last;

`ifndef NO_ASSERTIONS
  a_start_wait_only_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_wait_before_us != '0 |->
      out_nibble == 4'h3 && !out_register_select && !out_last)
    else $error("start wait on a nibble that is not the first init nibble");

  a_last_has_no_follow_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !(out_strobe && out_wait_before_us == '0 && out_last
      && out_wait_after_us != '0 && out_register_select))
    else $error("character nibble carries a settling wait");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("sequencer took an item from an empty queue");

  a_pulse_reg_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(enable_pulse_r))
    else $error("pulse width register changed without a write");
`endif

endmodule

@@ bench/char_lcd_nibble_writer_tb.sv @@
`timescale 1ns / 1ps

module char_lcd_nibble_writer_tb;
  import cln_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  // Power-up sequence, first byte in the top bits.
  localparam logic [79:0] INIT_SEQ = {8'h30, 8'h30, 8'h30, 8'h20, 8'h28,
                                      8'h08, 8'h01, 8'h0C, 8'h06, 8'h01};
  localparam logic [129:0] INIT_SETTLE = {13'd5000, 13'd100, 13'd100, 13'd100, 13'd40,
                                          13'd0, 13'd3000, 13'd0, 13'd0, 13'd3000};
  localparam logic [31:0] ROW_BASES = {8'h54, 8'h14, 8'h40, 8'h00};
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_value;
    logic [7:0] column;
    logic [1:0] row;
  } lcd_request_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [7:0]  in_byte_value;
  logic [7:0]  in_column;
  logic [1:0]  in_row;
  logic        out_strobe;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic [16:0] out_wait_before_us;
  logic [12:0] out_wait_after_us;
  logic        out_last;
  logic        cfg_we;
  logic [7:0]  cfg_enable_pulse_us;

  lcd_request_t pending_requests[$];
  result_t      pulse_q[$];
  int           hold_pct;
  int           errors;

  char_lcd_nibble_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_byte_value       (in_byte_value),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_strobe          (out_strobe),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_before_us  (out_wait_before_us),
    .out_wait_after_us   (out_wait_after_us),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_enable_pulse_us (cfg_enable_pulse_us)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [16:0] pre_wait,
                           input logic [12:0] post_wait, input logic fin);
    result_t p;
    p.rs = rs;
    p.nibble = b[7:4];
    p.wait_before = pre_wait;
    p.wait_after = '0;
    p.last = 1'b0;
    pulse_q.push_back(p);
    p.nibble = b[3:0];
    p.wait_before = '0;
    p.wait_after = post_wait;
    p.last = fin;
    pulse_q.push_back(p);
  endtask

  task automatic predict_pulses(input logic [2:0] cmd, input logic [7:0] bval,
                                input logic [7:0] col, input logic [1:0] row);
    logic [7:0] addr;
    case (cmd)
      CMD_INIT: begin
        for (int i = 0; i < 10; i++) begin
          push_byte(1'b0, INIT_SEQ[8*(9-i) +: 8], (i == 0) ? START_WAIT_US : 17'd0,
                    INIT_SETTLE[13*(9-i) +: 13], i == 9);
        end
      end
      CMD_BYTE:  push_byte(1'b0, bval, '0, '0, 1'b1);
      CMD_CHAR:  push_byte(1'b1, bval, '0, '0, 1'b1);
      CMD_CLEAR: push_byte(1'b0, CLEAR_BYTE, '0, CLEAR_WAIT_US, 1'b1);
      CMD_HOME:  push_byte(1'b0, SETADDR_BYTE, '0, '0, 1'b1);
      CMD_GOTO: begin
        addr = SETADDR_BYTE + ROW_BASES[8*row +: 8] + col;
        push_byte(1'b0, addr, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_pulses(in_command, in_byte_value, in_column, in_row);
        void'(pending_requests.pop_front());
      end
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= hold_pct) begin
        start <= 1'b1;
        in_command <= pending_requests[0].command;
        in_byte_value <= pending_requests[0].byte_value;
        in_column <= pending_requests[0].column;
        in_row <= pending_requests[0].row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (pulse_q.size() == 0) begin
        $display("%0t: unexpected pulse, expected none, got rs=%0d nibble=%h last=%0d",
                 $time, out_register_select, out_nibble, out_last);
        errors++;
      end else begin
        want = pulse_q.pop_front();
        if (out_register_select !== want.rs) begin
          $display("%0t: register_select expected %0d, got %0d",
                   $time, want.rs, out_register_select);
          errors++;
        end
        if (out_nibble !== want.nibble) begin
          $display("%0t: nibble expected %h, got %h", $time, want.nibble, out_nibble);
          errors++;
        end
        if (out_wait_before_us !== want.wait_before) begin
          $display("%0t: wait_before_us expected %0d, got %0d",
                   $time, want.wait_before, out_wait_before_us);
          errors++;
        end
        if (out_wait_after_us !== want.wait_after) begin
          $display("%0t: wait_after_us expected %0d, got %0d",
                   $time, want.wait_after, out_wait_after_us);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d, got %0d", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic queue_request(input logic [2:0] cmd, input logic [7:0] bval,
                               input logic [7:0] col, input logic [1:0] row);
    lcd_request_t r;
    r.command = cmd;
    r.byte_value = bval;
    r.column = col;
    r.row = row;
    pending_requests.push_back(r);
  endtask

  task automatic queue_random_requests(input int count);
    int queued;
    int pick;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_request(CMD_INIT, 8'($urandom), 8'($urandom), 2'($urandom));
        queued++;
      end else if (pick < 10) begin
        queue_request(($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B,
                      8'($urandom), 8'($urandom), 2'($urandom));
      end else begin
        queue_request(3'($urandom_range(CMD_BYTE, CMD_GOTO)), 8'($urandom), 8'($urandom),
                      2'($urandom));
        queued++;
      end
    end
  endtask

  // Returns once every queued item has been taken and every pulse has come out.
  task automatic wait_until_idle();
    while (pending_requests.size() != 0 || start || pulse_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pulse_width(input logic [7:0] width_us);
    cfg_we <= 1'b1;
    cfg_enable_pulse_us <= width_us;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    errors = 0;
    hold_pct = 10;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_INIT;
    in_byte_value = '0;
    in_column = '0;
    in_row = '0;
    cfg_we = 1'b0;
    cfg_enable_pulse_us = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_pulse_width(8'd1);
    queue_request(CMD_INIT, 8'h00, 8'h00, 2'd0);
    queue_request(CMD_BYTE, 8'h00, 8'hFF, 2'd3);
    queue_request(CMD_BYTE, 8'hFF, 8'h00, 2'd0);
    queue_request(CMD_CHAR, 8'h00, 8'h00, 2'd0);
    queue_request(CMD_CHAR, 8'hFF, 8'hFF, 2'd3);
    queue_request(CMD_CHAR, 8'hA5, 8'h5A, 2'd1);
    queue_request(CMD_CLEAR, 8'hFF, 8'hFF, 2'd3);
    queue_request(CMD_HOME, 8'hFF, 8'hFF, 2'd3);
    queue_request(CMD_GOTO, 8'h00, 8'h00, 2'd0);
    queue_request(CMD_GOTO, 8'h00, 8'h0F, 2'd1);
    queue_request(CMD_GOTO, 8'h00, 8'h13, 2'd2);
    queue_request(CMD_GOTO, 8'h00, 8'h13, 2'd3);
    queue_request(CMD_GOTO, 8'h00, 8'hFF, 2'd0);
    queue_request(CMD_GOTO, 8'h00, 8'hFF, 2'd3);
    queue_request(CMD_GOTO, 8'h00, 8'h80, 2'd1);
    queue_request(CMD_SPARE_A, 8'hFF, 8'hFF, 2'd3);
    queue_request(CMD_SPARE_B, 8'h00, 8'h00, 2'd0);
    queue_request(CMD_HOME, 8'h00, 8'h00, 2'd0);
    queue_request(CMD_INIT, 8'hFF, 8'hFF, 2'd3);
    wait_until_idle();

    write_pulse_width(8'd255);
    queue_random_requests(44);
    wait_until_idle();

    hold_pct = 83;
    write_pulse_width(8'($urandom_range(0, 255)));
    queue_random_requests(44);
    wait_until_idle();

    hold_pct = 0;
    write_pulse_width(8'd30);
    queue_random_requests(44);
    wait_until_idle();

    if (pulse_q.size() != 0) begin
      $display("%0t: %0d expected pulses never appeared", $time, pulse_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ char_lcd_nibble_writer.f @@
hw/rtl/cln_pkg.sv
hw/rtl/cln_front.sv
hw/rtl/cln_queue.sv
hw/rtl/cln_back.sv
hw/rtl/char_lcd_nibble_writer.sv
bench/char_lcd_nibble_writer_tb.sv
